[sv/irsp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the index record stream parser.
// No dependencies; every other file of the block imports this package.
package irsp_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned FIXED_BYTES  = 48;
    localparam int unsigned FIXED_BITS   = FIXED_BYTES * 8;
    localparam int unsigned HOLD_BITS    = (FIXED_BYTES - 1) * 8;

    localparam logic [19:0] MAX_ENTRIES_RESET = 20'd1000000;

    // Result status codes.
    localparam logic [3:0] ST_PATH    = 4'd0;
    localparam logic [3:0] ST_RECORD  = 4'd1;
    localparam logic [3:0] ST_SHORT   = 4'd2;
    localparam logic [3:0] ST_VERSION = 4'd3;
    localparam logic [3:0] ST_EMPTY   = 4'd4;
    localparam logic [3:0] ST_MANY    = 4'd5;
    localparam logic [3:0] ST_BADLEN  = 4'd6;
    localparam logic [3:0] ST_TRUNC   = 4'd7;
    localparam logic [3:0] ST_COUNT   = 4'd8;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_PATH,
        PH_FIXED,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic                  has_result;
        logic [3:0]            status;
        logic [19:0]           entry_number;
        logic [7:0]            path_char;
        logic [12:0]           path_length;
        logic [FIXED_BITS-1:0] fixed_bytes;
    } parse_result_t;

endpackage

[sv/index_record_stream_parser.sv]
`timescale 1ns / 1ps
// Index record stream parser: one blob byte per input transaction, at most
// one result transaction per byte. Builds on irsp_parser and irsp_out_reg.
//
// Input channel: in_valid/in_stall with data_byte and last_byte. Output
// channel: out_valid/out_stall with status, entry_number, path fields and
// the fixed fields of a completed entry (zero where they do not apply).
// Users write max_entries (cfg_we/cfg_wdata) only when idle; not enforced.
//
// Throughput is one byte per cycle: the parse engine handles a byte in the
// cycle it is accepted and writes its result straight into the result
// register, so results show in the cycle after the byte that causes them.
// in_stall is high only while that register holds a result the receiver
// is stalling; a byte that yields no result still waits for it.
//
// Reset returns the parser to the header phase with max_entries at
// 1000000 and drops any pending result. The final byte of a blob rearms
// the parser whatever its phase.
module index_record_stream_parser
    import irsp_pkg::*;
#(
    parameter int MAX_PATH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [19:0] entry_number,
    output logic [7:0]  path_char,
    output logic [12:0] path_length,
    output logic [63:0] object_offset,
    output logic [63:0] object_size,
    output logic [31:0] file_mode,
    output logic [63:0] modify_time_ns,
    output logic [31:0] compression_kind,
    output logic [31:0] encryption_kind,
    output logic [63:0] original_size,
    output logic [31:0] content_crc
);

    logic [19:0]   max_entries_reg;
    logic          take;
    logic          busy;
    parse_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else if (cfg_we)
        begin
            max_entries_reg <= cfg_wdata;
        end
    end

    assign in_stall = busy;
    assign take     = in_valid & ~busy;

    irsp_parser #(
        .MAX_PATH (MAX_PATH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .max_entries (max_entries_reg),
        .result      (result)
    );

    irsp_out_reg u_out (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .result           (result),
        .out_stall        (out_stall),
        .busy             (busy),
        .out_valid        (out_valid),
        .status           (status),
        .entry_number     (entry_number),
        .path_char        (path_char),
        .path_length      (path_length),
        .object_offset    (object_offset),
        .object_size      (object_size),
        .file_mode        (file_mode),
        .modify_time_ns   (modify_time_ns),
        .compression_kind (compression_kind),
        .encryption_kind  (encryption_kind),
        .original_size    (original_size),
        .content_crc      (content_crc)
    );

endmodule

[sv/irsp_parser.sv]
`timescale 1ns / 1ps
// Byte-wise parse engine: phase, counters, header/length assembly and the
// fixed-field shift buffer. Depends on irsp_pkg.
module irsp_parser
    import irsp_pkg::*;
#(
    parameter int MAX_PATH = 4096
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic [19:0]   max_entries,
    output parse_result_t result
);

    localparam int LEFT_W = $clog2(MAX_PATH + 1);

    phase_t                phase_reg, phase_next;
    logic [5:0]            pos_reg, pos_next;
    logic [31:0]           word_reg, word_next;
    logic                  ver_reg, ver_next;
    logic [19:0]           exp_reg, exp_next;
    logic [19:0]           seen_reg, seen_next;
    logic [12:0]           len_reg, len_next;
    logic [LEFT_W-1:0]     left_reg, left_next;
    logic [HOLD_BITS-1:0]  hold_reg, hold_next;

    logic [31:0]           shifted;
    logic [LEFT_W-1:0]     left_dec;
    logic [19:0]           seen_inc;

    assign shifted  = {data_byte, word_reg[31:8]};
    assign left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
    assign seen_inc = seen_reg + 20'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        ver_next   = ver_reg;
        exp_next   = exp_reg;
        seen_next  = seen_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        hold_next  = hold_reg;
        result     = '0;

        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    word_next = shifted;
                    if (pos_reg == 6'd3)
                    begin
                        ver_next = (shifted == 32'd1);
                    end
                    if (pos_reg < 6'(HEADER_BYTES - 1))
                    begin
                        pos_next = pos_reg + 6'd1;
                        if (last_byte)
                        begin
                            result.has_result = 1'b1;
                            result.status     = ST_SHORT;
                            phase_next        = PH_ERROR;
                        end
                    end
                    else if (!ver_reg)
                    begin
                        result.has_result = 1'b1;
                        result.status     = ST_VERSION;
                        phase_next        = PH_ERROR;
                    end
                    else if (shifted == 32'd0)
                    begin
                        result.has_result = 1'b1;
                        result.status     = ST_EMPTY;
                        phase_next        = PH_ERROR;
                    end
                    else if (shifted > {12'd0, max_entries})
                    begin
                        result.has_result = 1'b1;
                        result.status     = ST_MANY;
                        phase_next        = PH_ERROR;
                    end
                    else
                    begin
                        exp_next   = shifted[19:0];
                        phase_next = PH_LENGTH;
                        pos_next   = '0;
                        word_next  = '0;
                        if (last_byte)
                        begin
                            result.has_result = 1'b1;
                            result.status     = ST_COUNT;
                            phase_next        = PH_ERROR;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    word_next = shifted;
                    if (pos_reg < 6'd3)
                    begin
                        pos_next = pos_reg + 6'd1;
                        if (last_byte)
                        begin
                            result.has_result   = 1'b1;
                            result.status       = ST_TRUNC;
                            result.entry_number = seen_reg;
                            phase_next          = PH_ERROR;
                        end
                    end
                    else if (shifted == 32'd0 || shifted > 32'(MAX_PATH))
                    begin
                        result.has_result   = 1'b1;
                        result.status       = ST_BADLEN;
                        result.entry_number = seen_reg;
                        phase_next          = PH_ERROR;
                    end
                    else if (last_byte)
                    begin
                        result.has_result   = 1'b1;
                        result.status       = ST_TRUNC;
                        result.entry_number = seen_reg;
                        phase_next          = PH_ERROR;
                    end
                    else
                    begin
                        // The length is at most MAX_PATH here, so the slices keep it whole.
                        len_next   = shifted[12:0];
                        left_next  = shifted[LEFT_W-1:0];
                        phase_next = PH_PATH;
                        pos_next   = '0;
                    end
                end
                PH_PATH:
                begin
                    result.has_result   = 1'b1;
                    result.entry_number = seen_reg;
                    if (last_byte)
                    begin
                        result.status = ST_TRUNC;
                        phase_next    = PH_ERROR;
                    end
                    else
                    begin
                        result.status      = ST_PATH;
                        result.path_char   = data_byte;
                        result.path_length = len_reg;
                        left_next          = left_dec;
                        if (left_dec == '0)
                        begin
                            phase_next = PH_FIXED;
                            pos_next   = '0;
                        end
                    end
                end
                PH_FIXED:
                begin
                    // Bytes enter at the top, so after 47 shifts byte 0 sits lowest.
                    hold_next = {data_byte, hold_reg[HOLD_BITS-1:8]};
                    if (pos_reg < 6'(FIXED_BYTES - 1))
                    begin
                        pos_next = pos_reg + 6'd1;
                        if (last_byte)
                        begin
                            result.has_result   = 1'b1;
                            result.status       = ST_TRUNC;
                            result.entry_number = seen_reg;
                            phase_next          = PH_ERROR;
                        end
                    end
                    else
                    begin
                        seen_next = seen_inc;
                        result.has_result = 1'b1;
                        if (seen_inc != exp_reg && last_byte)
                        begin
                            result.status       = ST_COUNT;
                            result.entry_number = seen_inc;
                            phase_next          = PH_ERROR;
                        end
                        else
                        begin
                            result.status       = ST_RECORD;
                            result.entry_number = seen_reg;
                            result.path_length  = len_reg;
                            result.fixed_bytes  = {data_byte, hold_reg};
                            pos_next            = '0;
                            word_next           = '0;
                            phase_next = (seen_inc == exp_reg) ? PH_DONE : PH_LENGTH;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // The final byte of a blob always returns the parser to the header.
            if (last_byte)
            begin
                phase_next = PH_HEADER;
                pos_next   = '0;
                word_next  = '0;
                ver_next   = 1'b0;
                exp_next   = '0;
                seen_next  = '0;
                len_next   = '0;
                left_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            word_reg  <= '0;
            ver_reg   <= 1'b0;
            exp_reg   <= '0;
            seen_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            word_reg  <= word_next;
            ver_reg   <= ver_next;
            exp_reg   <= exp_next;
            seen_reg  <= seen_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

[sv/irsp_out_reg.sv]
`timescale 1ns / 1ps
// Result register: holds one parse result until the receiver takes it and
// splits the fixed-field bytes into the output words. Depends on irsp_pkg.
module irsp_out_reg
    import irsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  parse_result_t result,
    input  logic          out_stall,
    output logic          busy,
    output logic          out_valid,
    output logic [3:0]    status,
    output logic [19:0]   entry_number,
    output logic [7:0]    path_char,
    output logic [12:0]   path_length,
    output logic [63:0]   object_offset,
    output logic [63:0]   object_size,
    output logic [31:0]   file_mode,
    output logic [63:0]   modify_time_ns,
    output logic [31:0]   compression_kind,
    output logic [31:0]   encryption_kind,
    output logic [63:0]   original_size,
    output logic [31:0]   content_crc
);

    logic          valid_reg, valid_next;
    parse_result_t res_reg;
    logic          load;

    // A full register that is stalled holds the input side back.
    assign busy       = valid_reg & out_stall;
    assign load       = take & result.has_result;
    assign valid_next = load | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid        = valid_reg;
    assign status           = res_reg.status;
    assign entry_number     = res_reg.entry_number;
    assign path_char        = res_reg.path_char;
    assign path_length      = res_reg.path_length;
    assign object_offset    = res_reg.fixed_bytes[63:0];
    assign object_size      = res_reg.fixed_bytes[127:64];
    assign file_mode        = res_reg.fixed_bytes[159:128];
    assign modify_time_ns   = res_reg.fixed_bytes[223:160];
    assign compression_kind = res_reg.fixed_bytes[255:224];
    assign encryption_kind  = res_reg.fixed_bytes[287:256];
    assign original_size    = res_reg.fixed_bytes[351:288];
    assign content_crc      = res_reg.fixed_bytes[383:352];

endmodule

[sv/irsp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the index record stream parser, bound to the top
// level below. Depends on irsp_pkg for the status codes.
module irsp_checker
    import irsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  status,
    input logic [7:0]  path_char,
    input logic [63:0] object_offset
);

    // A held result must stay visible until the receiver takes it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // The input side is held back only by a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a pending result");

    // With nothing accepted and the result taken, no new result may appear.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) && !(in_valid && !in_stall) |=> !out_valid)
        else $error("result appeared without an input transaction");

    // Non-path, non-record results carry zero path_char and object_offset.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PATH && status != ST_RECORD |->
            path_char == 8'd0 && object_offset == 64'd0)
        else $error("error result carries payload bits");

    // The status code never exceeds the last defined code.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_COUNT)
        else $error("undefined status code");

endmodule

bind index_record_stream_parser irsp_checker u_irsp_checker (.*);

[tb/sv/index_parse_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the index record stream parser: follows the byte channel, the
// result channel and the max_entries port, predicts each result and compares.
// Depends on irsp_pkg for status codes, parse phases and sizes.
module index_parse_checker
    import irsp_pkg::*;
#(
    parameter int MAX_PATH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  status,
    input  logic [19:0] entry_number,
    input  logic [7:0]  path_char,
    input  logic [12:0] path_length,
    input  logic [63:0] object_offset,
    input  logic [63:0] object_size,
    input  logic [31:0] file_mode,
    input  logic [63:0] modify_time_ns,
    input  logic [31:0] compression_kind,
    input  logic [31:0] encryption_kind,
    input  logic [63:0] original_size,
    input  logic [31:0] content_crc,
    output int          pending,
    output int          mismatches,
    output int          results_checked
);

    typedef struct packed {
        logic [3:0]  status;
        logic [19:0] entry_number;
        logic [7:0]  path_char;
        logic [12:0] path_length;
        logic [63:0] object_offset;
        logic [63:0] object_size;
        logic [31:0] file_mode;
        logic [63:0] modify_time_ns;
        logic [31:0] compression_kind;
        logic [31:0] encryption_kind;
        logic [63:0] original_size;
        logic [31:0] content_crc;
    } index_result_t;

    phase_t                phase;
    logic [5:0]            pos;
    logic [31:0]           word;
    logic [19:0]           wanted_entries;
    logic [19:0]           seen_entries;
    logic [12:0]           path_size;
    logic [31:0]           path_left;
    logic [FIXED_BITS-1:0] fixed_buf;
    logic                  version_ok;
    logic [19:0]           entry_limit;

    index_result_t expected_results[$];
    index_result_t observed;
    index_result_t oldest;
    index_result_t predicted;
    int            fail_count;
    int            match_count;

    function automatic void rearm_parser();
        phase          = PH_HEADER;
        pos            = '0;
        word           = '0;
        wanted_entries = '0;
        seen_entries   = '0;
        path_size      = '0;
        path_left      = '0;
        version_ok     = 1'b0;
    endfunction

    // An error result; the parser then ignores bytes until the final one.
    function automatic index_result_t parse_error(input logic [3:0] code,
                                                  input logic [19:0] entry);
        index_result_t r;
        r              = '0;
        r.status       = code;
        r.entry_number = entry;
        phase          = PH_ERROR;
        return r;
    endfunction

    // Advances the predicted parser by one byte; returns 1 when a result is due.
    function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                      output index_result_t r);
        bit has;
        has = 1'b0;
        r   = '0;
        case (phase)
            PH_HEADER:
            begin
                word = {b, word[31:8]};
                if (pos == 6'd3)
                    version_ok = (word == 32'd1);
                if (pos < HEADER_BYTES - 1)
                begin
                    pos = pos + 6'd1;
                    if (fin)
                    begin
                        r   = parse_error(ST_SHORT, '0);
                        has = 1'b1;
                    end
                end
                else if (!version_ok)
                begin
                    r   = parse_error(ST_VERSION, '0);
                    has = 1'b1;
                end
                else if (word == 32'd0)
                begin
                    r   = parse_error(ST_EMPTY, '0);
                    has = 1'b1;
                end
                else if (word > {12'd0, entry_limit})
                begin
                    r   = parse_error(ST_MANY, '0);
                    has = 1'b1;
                end
                else
                begin
                    wanted_entries = word[19:0];
                    phase          = PH_LENGTH;
                    pos            = '0;
                    word           = '0;
                    if (fin)
                    begin
                        r   = parse_error(ST_COUNT, '0);
                        has = 1'b1;
                    end
                end
            end
            PH_LENGTH:
            begin
                word = {b, word[31:8]};
                if (pos < 6'd3)
                begin
                    pos = pos + 6'd1;
                    if (fin)
                    begin
                        r   = parse_error(ST_TRUNC, seen_entries);
                        has = 1'b1;
                    end
                end
                else if (word == 32'd0 || word > MAX_PATH)
                begin
                    r   = parse_error(ST_BADLEN, seen_entries);
                    has = 1'b1;
                end
                else if (fin)
                begin
                    r   = parse_error(ST_TRUNC, seen_entries);
                    has = 1'b1;
                end
                else
                begin
                    path_size = word[12:0];
                    path_left = word;
                    phase     = PH_PATH;
                    pos       = '0;
                end
            end
            PH_PATH:
            begin
                has = 1'b1;
                if (fin)
                    r = parse_error(ST_TRUNC, seen_entries);
                else
                begin
                    r.status       = ST_PATH;
                    r.entry_number = seen_entries;
                    r.path_char    = b;
                    r.path_length  = path_size;
                    if (path_left != 32'd0)
                        path_left = path_left - 32'd1;
                    if (path_left == 32'd0)
                    begin
                        phase = PH_FIXED;
                        pos   = '0;
                    end
                end
            end
            PH_FIXED:
            begin
                fixed_buf[int'(pos) * 8 +: 8] = b;
                if (pos < FIXED_BYTES - 1)
                begin
                    pos = pos + 6'd1;
                    if (fin)
                    begin
                        r   = parse_error(ST_TRUNC, seen_entries);
                        has = 1'b1;
                    end
                end
                else
                begin
                    seen_entries = seen_entries + 20'd1;
                    has          = 1'b1;
                    // A blob that ends on a complete entry with more still owed
                    // reports the short count in place of the record.
                    if (seen_entries != wanted_entries && fin)
                        r = parse_error(ST_COUNT, seen_entries);
                    else
                    begin
                        r.status           = ST_RECORD;
                        r.entry_number     = seen_entries - 20'd1;
                        r.path_length      = path_size;
                        r.object_offset    = fixed_buf[63:0];
                        r.object_size      = fixed_buf[127:64];
                        r.file_mode        = fixed_buf[159:128];
                        r.modify_time_ns   = fixed_buf[223:160];
                        r.compression_kind = fixed_buf[255:224];
                        r.encryption_kind  = fixed_buf[287:256];
                        r.original_size    = fixed_buf[351:288];
                        r.content_crc      = fixed_buf[383:352];
                        pos                = '0;
                        word               = '0;
                        phase = (seen_entries == wanted_entries) ? PH_DONE : PH_LENGTH;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (fin)
            rearm_parser();
        return has;
    endfunction

    function automatic string describe(input index_result_t r);
        return {$sformatf("status %0d entry %0d char %02h len %0d", r.status,
                          r.entry_number, r.path_char, r.path_length),
                $sformatf(" off %h size %h mode %h mtime %h", r.object_offset,
                          r.object_size, r.file_mode, r.modify_time_ns),
                $sformatf(" comp %h enc %h orig %h crc %h", r.compression_kind,
                          r.encryption_kind, r.original_size, r.content_crc)};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rearm_parser();
            entry_limit = MAX_ENTRIES_RESET;
            fixed_buf   = '0;
            expected_results.delete();
            fail_count      = 0;
            match_count     = 0;
            pending         <= 0;
            mismatches      <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                observed = '{status: status, entry_number: entry_number,
                             path_char: path_char, path_length: path_length,
                             object_offset: object_offset, object_size: object_size,
                             file_mode: file_mode, modify_time_ns: modify_time_ns,
                             compression_kind: compression_kind,
                             encryption_kind: encryption_kind,
                             original_size: original_size, content_crc: content_crc};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("checker: unexpected result %s", describe(observed));
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    match_count++;
                    if (observed !== oldest)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("checker: result %0d differs", match_count);
                            $display("  expected %s", describe(oldest));
                            $display("  actual   %s", describe(observed));
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (parse_byte(data_byte, last_byte, predicted))
                    expected_results.push_back(predicted);
            end

            // A byte taken at the same edge as a write still sees the old limit.
            if (cfg_we)
                entry_limit = cfg_wdata;

            pending         <= expected_results.size();
            mismatches      <= fail_count;
            results_checked <= match_count;
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the parser testbench: clock, reset, index blob stimulus and verdict.
// Depends on irsp_pkg, index_record_stream_parser and index_parse_checker.
module tb;
    import irsp_pkg::*;

    localparam int MAX_PATH       = 4096;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [19:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  status;
    logic [19:0] entry_number;
    logic [7:0]  path_char;
    logic [12:0] path_length;
    logic [63:0] object_offset;
    logic [63:0] object_size;
    logic [31:0] file_mode;
    logic [63:0] modify_time_ns;
    logic [31:0] compression_kind;
    logic [31:0] encryption_kind;
    logic [63:0] original_size;
    logic [31:0] content_crc;

    int          pending;
    int          mismatches;
    int          results_checked;

    logic [7:0]  blob[$];
    int unsigned limit_now = MAX_ENTRIES_RESET;
    bit          quiet = 1'b0;
    int          blobs_sent = 0;
    int          bytes_sent = 0;
    int          idle_cycles = 0;

    index_record_stream_parser #(.MAX_PATH(MAX_PATH)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
        .last_byte(last_byte), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .entry_number(entry_number), .path_char(path_char),
        .path_length(path_length), .object_offset(object_offset),
        .object_size(object_size), .file_mode(file_mode),
        .modify_time_ns(modify_time_ns), .compression_kind(compression_kind),
        .encryption_kind(encryption_kind), .original_size(original_size),
        .content_crc(content_crc)
    );

    index_parse_checker #(.MAX_PATH(MAX_PATH)) parse_check (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
        .last_byte(last_byte), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .entry_number(entry_number), .path_char(path_char),
        .path_length(path_length), .object_offset(object_offset),
        .object_size(object_size), .file_mode(file_mode),
        .modify_time_ns(modify_time_ns), .compression_kind(compression_kind),
        .encryption_kind(encryption_kind), .original_size(original_size),
        .content_crc(content_crc), .pending(pending), .mismatches(mismatches),
        .results_checked(results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls now and then, except during the quiet stretch.
    always @(posedge clk)
        out_stall <= rst_n && !quiet && ($urandom_range(99) < 6);

    // Ends the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: no transaction for %0d cycles", idle_cycles);
            $display("tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic put_le32(input logic [31:0] value);
        for (int i = 0; i < 4; i++)
            blob.push_back(value[8*i +: 8]);
    endtask

    // One entry: length word, random path bytes, then the fixed fields, which
    // are random when fill is negative and that byte value otherwise.
    task automatic put_entry(input int len, input int fill);
        put_le32(len);
        repeat (len)
            blob.push_back(8'($urandom_range(255)));
        repeat (FIXED_BYTES)
            blob.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
    endtask

    task automatic cut_blob(input int keep);
        while (blob.size() > keep)
            void'(blob.pop_back());
    endtask

    function automatic int pick_path_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return $urandom_range(1, 12);
        if (roll < 98)
            return $urandom_range(13, 80);
        return $urandom_range(81, 300);
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic fin);
        if (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_blob();
        foreach (blob[i])
            send_byte(blob[i], i == blob.size() - 1);
        blobs_sent++;
        bytes_sent += blob.size();
        blob.delete();
    endtask

    // Waits until every predicted result has been taken, plus a short margin
    // for a byte that produced nothing.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input int unsigned value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[19:0];
        limit_now = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic build_random_blob();
        int          kind;
        int          count;
        int          done_entries;
        int          most;
        logic [31:0] value;
        kind  = $urandom_range(99);
        most  = (limit_now > 4) ? 4 : int'(limit_now);
        count = (most == 0) ? 1 : $urandom_range(1, most);
        if (kind < 75)
        begin
            // Well-formed blob, kept whole with up to three stray bytes added, or cut at any byte.
            put_le32(1);
            put_le32(count);
            repeat (count)
                put_entry(pick_path_size(), -1);
            if (kind < 60)
                repeat ($urandom_range(0, 3))
                    blob.push_back(8'($urandom_range(255)));
            else
                cut_blob($urandom_range(1, blob.size()));
        end
        else if (kind < 80)
        begin
            value = $urandom;
            if (value == 32'd1)
                value = 32'd0;
            put_le32(value);
            put_le32($urandom);
            repeat ($urandom_range(0, 4))
                blob.push_back(8'($urandom_range(255)));
        end
        else if (kind < 83)
        begin
            put_le32(1);
            put_le32(0);
        end
        else if (kind < 87)
        begin
            put_le32(1);
            if ($urandom_range(3) == 0)
                put_le32($urandom | 32'h0010_0000);
            else
                put_le32(limit_now + 1 + $urandom_range(0, 2));
            repeat ($urandom_range(0, 4))
                blob.push_back(8'($urandom_range(255)));
        end
        else if (kind < 92)
        begin
            put_le32(1);
            put_le32(count);
            repeat ($urandom_range(0, count - 1))
                put_entry(pick_path_size(), -1);
            if ($urandom_range(1) == 0)
                put_le32(0);
            else
                put_le32($urandom_range(32'hFFFF_FFFF, MAX_PATH + 1));
            repeat ($urandom_range(0, 5))
                blob.push_back(8'($urandom_range(255)));
        end
        else if (kind < 96)
        begin
            // Ends cleanly after fewer entries than the header promised.
            done_entries = $urandom_range(0, 2);
            value = done_entries + $urandom_range(1, 3);
            if ($urandom_range(3) == 0 && limit_now > done_entries)
                value = limit_now;
            put_le32(1);
            put_le32(value);
            repeat (done_entries)
                put_entry(pick_path_size(), -1);
        end
        else
            repeat ($urandom_range(1, 20))
                blob.push_back(8'($urandom_range(255)));
    endtask

    initial
    begin : stimulus
        int unsigned settings[6];
        int          phase_bytes;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone final byte is a short header.
        blob.push_back(8'h01);
        send_blob();
        // A valid header that is also the end of the blob.
        put_le32(1);
        put_le32(1);
        send_blob();
        // Version with its 1 in the wrong byte, then a bad version that also has an
        // empty count; the version check wins.
        put_le32(32'h0000_0100);
        put_le32(1);
        blob.push_back(8'hFF);
        send_blob();
        put_le32(32'hFFFF_FFFF);
        put_le32(0);
        send_blob();
        put_le32(1);
        put_le32(0);
        send_blob();
        put_le32(1);
        put_le32(MAX_ENTRIES_RESET + 1);
        send_blob();
        put_le32(1);
        put_le32(32'hFFFF_FFFF);
        send_blob();
        // Bad length on the final byte still reports bad length.
        put_le32(1);
        put_le32(1);
        put_le32(0);
        send_blob();
        put_le32(1);
        put_le32(1);
        put_le32(MAX_PATH + 1);
        put_le32(7);
        send_blob();
        put_le32(1);
        put_le32(1);
        put_le32(32'hFFFF_FFFF);
        send_blob();
        // Truncation inside a length word, at its end, on a path byte and in
        // the fixed fields.
        put_le32(1);
        put_le32(1);
        put_le32(5);
        cut_blob(10);
        send_blob();
        put_le32(1);
        put_le32(1);
        put_le32(5);
        send_blob();
        put_le32(1);
        put_le32(1);
        put_entry(3, -1);
        cut_blob(14);
        send_blob();
        put_le32(1);
        put_le32(1);
        put_entry(1, -1);
        cut_blob(33);
        send_blob();
        // The final byte completes an entry while another is still owed.
        put_le32(1);
        put_le32(2);
        put_entry(1, -1);
        send_blob();
        put_le32(1);
        put_le32(1);
        put_entry(1, 8'h00);
        send_blob();
        put_le32(1);
        put_le32(2);
        put_entry(2, 8'hFF);
        put_entry(1, 8'hFF);
        repeat (3)
            blob.push_back(8'($urandom_range(255)));
        send_blob();
        put_le32(1);
        put_le32(MAX_ENTRIES_RESET);
        put_entry(1, -1);
        send_blob();
        // A path of the largest legal length is accepted, then cut short.
        put_le32(1);
        put_le32(1);
        put_entry(MAX_PATH, -1);
        cut_blob(20);
        send_blob();

        settings = '{1, 0, 2, 20'hFFFFF, $urandom_range(3, 999999), MAX_ENTRIES_RESET};
        for (int p = 0; p < 6; p++)
        begin
            write_limit(settings[p]);
            quiet = (p == 3);
            phase_bytes = 0;
            while (phase_bytes < ((settings[p] == 0) ? 100 : 160))
            begin
                build_random_blob();
                phase_bytes += blob.size();
                send_blob();
            end
        end
        quiet = 1'b0;

        settle();
        repeat (4) @(posedge clk);
        $display("tb: %0d blobs, %0d bytes streamed, %0d results compared",
                 blobs_sent, bytes_sent, results_checked);
        $display("tb: max_entries went through 1000000, 1, 0, 2, 1048575 and %0d",
                 settings[4]);
        if (mismatches == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
sv/irsp_pkg.sv
sv/irsp_parser.sv
sv/irsp_out_reg.sv
sv/index_record_stream_parser.sv
sv/irsp_checker.sv
tb/sv/index_parse_checker.sv
tb/sv/tb.sv
